### rtl/u2u8_pkg.sv
`default_nettype none

package u2u8_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [20:0] ReplCp = 21'h00FFFD;

    // Positions of a byte within the encoding of one code point.
    localparam logic [1:0] IdxLead  = 2'd0;
    localparam logic [1:0] IdxOne   = 2'd1;
    localparam logic [1:0] IdxTwo   = 2'd2;
    localparam logic [1:0] IdxThree = 2'd3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } t_out_item;

    // One unit of work for the byte sequencer: an optional replacement
    // character, then an optional code point, then the string flag.
    typedef struct packed {
        logic        repl_first;
        logic        has_cp;
        logic [20:0] cp;
        logic        last_unit;
    } t_job;

    // Index of the final byte of the UTF-8 form of a code point.
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp < 21'h80) begin
            r = IdxLead;
        end else if (cp < 21'h800) begin
            r = IdxOne;
        end else if (cp < 21'h10000) begin
            r = IdxTwo;
        end else begin
            r = IdxThree;
        end
        return r;
    endfunction

    // Byte number idx of the UTF-8 form of a code point.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [1:0] lidx;
        logic [1:0] k;
        logic [7:0] r;
        lidx = utf8_last_idx(cp);
        k    = lidx - idx;
        if (idx == IdxLead) begin
            unique case (lidx)
                IdxLead:  r = {1'b0, cp[6:0]};
                IdxOne:   r = {3'b110, cp[10:6]};
                IdxTwo:   r = {4'b1110, cp[15:12]};
                default:  r = {5'b11110, cp[20:18]};
            endcase
        end else begin
            unique case (k)
                2'd0:    r = {2'b10, cp[5:0]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[17:12]};
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/utf16_to_utf8_encoder_unit.sv
// UTF-16 to UTF-8 encoder.
// Input channel (i_in_valid, i_in_data, o_in_stall): one transaction carries one
// UTF-16 code unit and a flag that marks the final unit of a string.
// Output channel (o_out_valid, o_out_data, i_out_stall): one transaction carries
// one UTF-8 byte, with run_end on the final byte caused by an input transaction and
// string_end on the final byte of the string.
// The first byte of a unit passes through the job queue and then the output register
// before it is offered.
// Throughput: one byte per cycle while the receiver does not stall, set by the single
// output byte sequencer. A unit causes one to three bytes for a BMP character, four
// for a surrogate pair (counted on its low half), up to six when a dangling high
// surrogate adds U+FFFD. A held high surrogate causes no output byte.
// A four-entry job queue sits between the classifier and the sequencer, so input
// is taken while output is stalled until the queue fills; o_in_stall is high
// exactly when the queue is full.
// Reset (synchronous, active low) drops any held surrogate, empties the queue and
// clears the output valid flag. While the receiver stalls, the output transaction
// holds steady and the sequencer waits.

`default_nettype none

module utf16_to_utf8_encoder_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire u2u8_pkg::t_in_item  i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output u2u8_pkg::t_out_item      o_out_data,
    input  wire logic                i_out_stall
);

    logic           in_accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    u2u8_pkg::t_job front_job;
    u2u8_pkg::t_job head_job;

    // The queue being full is the only reason to refuse a unit.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // The front classifies each unit and tracks a held high surrogate.
    u2u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_job    (front_job)
    );

    u2u8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (head_job)
    );

    // The back walks the bytes of each job into the output register.
    u2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

### rtl/u2u8_front.sv
`default_nettype none

module u2u8_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire u2u8_pkg::t_in_item i_item,
    output logic                   o_push,
    output u2u8_pkg::t_job         o_job
);

    logic       r_pending;
    logic [9:0] r_high_bits;
    logic       n_pending;
    logic [9:0] n_high_bits;

    logic is_high;
    logic is_low;

    assign is_high = (i_item.code_unit[15:10] == 6'b110110);
    assign is_low  = (i_item.code_unit[15:10] == 6'b110111);

    always_comb begin
        o_job.repl_first = 1'b0;
        o_job.has_cp     = 1'b0;
        o_job.cp         = u2u8_pkg::ReplCp;
        o_job.last_unit  = i_item.last_unit;
        n_pending        = 1'b0;
        n_high_bits      = r_high_bits;
        if (r_pending && is_low) begin
            o_job.has_cp = 1'b1;
            o_job.cp     = 21'h10000 + {1'b0, r_high_bits, i_item.code_unit[9:0]};
        end else begin
            // A held high surrogate that is not completed becomes U+FFFD.
            o_job.repl_first = r_pending;
            if (is_high) begin
                if (i_item.last_unit) begin
                    o_job.has_cp = 1'b1;
                end else begin
                    n_pending   = 1'b1;
                    n_high_bits = i_item.code_unit[9:0];
                end
            end else if (is_low) begin
                o_job.has_cp = 1'b1;
            end else begin
                o_job.has_cp = 1'b1;
                o_job.cp     = {5'd0, i_item.code_unit};
            end
        end
        o_push = i_accept && (o_job.repl_first || o_job.has_cp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_high_bits <= n_high_bits;
        end
    end

endmodule

`default_nettype wire

### rtl/u2u8_queue.sv
`default_nettype none

module u2u8_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u2u8_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output u2u8_pkg::t_job      o_head
);

    u2u8_pkg::t_job r_mem [u2u8_pkg::QueueDepth];

    logic [u2u8_pkg::QueuePtrW-1:0] r_wr_ptr;
    logic [u2u8_pkg::QueuePtrW-1:0] r_rd_ptr;
    logic [u2u8_pkg::QueuePtrW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (u2u8_pkg::QueuePtrW + 1)'(u2u8_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/u2u8_back.sv
`default_nettype none

module u2u8_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire u2u8_pkg::t_job i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output u2u8_pkg::t_out_item o_out_data,
    input  wire logic           i_out_stall
);

    // r_main: the replacement part of the job is done.
    logic       r_main;
    logic [1:0] r_idx;
    logic       r_out_valid;
    u2u8_pkg::t_out_item r_out_data;

    logic        advance;
    logic        in_main;
    logic [20:0] cur_cp;
    logic        cp_done;
    logic        job_done;
    u2u8_pkg::t_out_item n_out_data;

    assign advance  = !r_out_valid || !i_out_stall;
    assign in_main  = r_main || !i_head.repl_first;
    assign cur_cp   = in_main ? i_head.cp : u2u8_pkg::ReplCp;
    assign cp_done  = (r_idx == u2u8_pkg::utf8_last_idx(cur_cp));
    assign job_done = cp_done && (in_main || !i_head.has_cp);
    assign o_pop    = advance && !i_empty && job_done;

    always_comb begin
        n_out_data.out_byte   = u2u8_pkg::utf8_byte(cur_cp, r_idx);
        n_out_data.run_end    = job_done;
        n_out_data.string_end = job_done && i_head.last_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main      <= 1'b0;
            r_idx       <= u2u8_pkg::IdxLead;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= !i_empty;
            if (!i_empty) begin
                if (job_done) begin
                    r_main <= 1'b0;
                    r_idx  <= u2u8_pkg::IdxLead;
                end else if (cp_done) begin
                    r_main <= 1'b1;
                    r_idx  <= u2u8_pkg::IdxLead;
                end else begin
                    r_idx  <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
